// ===== design/quad_batch_vertex_expander_unit_macros.svh =====
// assertion macros for the quad batch vertex expander
`ifndef QUAD_BATCH_VERTEX_EXPANDER_UNIT_MACROS_SVH
`define QUAD_BATCH_VERTEX_EXPANDER_UNIT_MACROS_SVH

// same-cycle implication
`define QBVE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qbve check failed");

// next-cycle implication
`define QBVE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qbve check failed");

`endif

// ===== design/qbve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbve_pkg
// shared types, constants and the sine table of the quad vertex expander
// ----------------------------------------------------------------------------
package qbve_pkg;

    localparam int SLOTS        = 32;
    localparam int SLOT_W       = 5;
    localparam int MAX_QUADS    = 16384;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = 10;
    localparam logic [14:0] QUAD_LIMIT_RESET = 15'd10000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // request codes
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    typedef logic signed [15:0] sin_lut_t [SINE_ENTRIES];

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       clr_batch;
        logic       emit_flush;
        logic       flush_last;
        logic       slot_assign;
        logic       emit_vert;
        logic [1:0] corner;
    } qbve_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       need_flush;
        logic       out_free;
    } qbve_status_t;

    // q1.14 sine of a phase in units of 2^-32 turn
    function automatic logic signed [15:0] sine_q14(logic [31:0] ph);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [15:0] v;
        q  = ph[31:30];
        r  = {34'd0, ph[29:0]};
        if (q[0])
            r = ONE_Q30 - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = 16'((s + 64'd32768) >> 16);
        return q[1] ? -$signed(v) : $signed(v);
    endfunction

    function automatic sin_lut_t build_sin();
        sin_lut_t tab;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            tab[i] = sine_q14(32'(i) << (32 - SINE_BITS));
        end
        return tab;
    endfunction

    localparam sin_lut_t SIN_LUT = build_sin();

endpackage

// ===== design/qbve_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbve_ctrl
// sequencer: decode, optional flush, slot assignment, four corner transactions
// ----------------------------------------------------------------------------
module qbve_ctrl
    import qbve_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  qbve_status_t status,
    output qbve_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_FLUSH  = 6'b000100,
        S_SLOT   = 6'b001000,
        S_VERT   = 6'b010000,
        S_END    = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] corner_reg, corner_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            corner_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        cmd         = '0;
        cmd.corner  = corner_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (status.func)
                    FUNC_DRAW:  state_next = status.need_flush ? S_FLUSH : S_SLOT;
                    FUNC_BEGIN:
                    begin
                        cmd.clr_batch = 1'b1;
                        state_next    = S_IDLE;
                    end
                    FUNC_END:   state_next = S_END;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.clr_batch  = 1'b1;
                    state_next     = S_SLOT;
                end
            end
            S_SLOT:
            begin
                cmd.slot_assign = 1'b1;
                corner_next     = 2'd0;
                state_next      = S_VERT;
            end
            S_VERT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_vert = 1'b1;
                    corner_next   = corner_reg + 2'd1;
                    if (corner_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (status.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.flush_last = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== design/qbve_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbve_dp
// datapath: input capture, slot table, batch counters, corner maths, output reg
// ----------------------------------------------------------------------------
module qbve_dp
    import qbve_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [14:0]         cfg_wdata,
    input  logic [1:0]          func,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  size_x,
    input  logic signed [31:0]  size_y,
    input  logic [15:0]         angle,
    input  logic                textured,
    input  logic [31:0]         texture_id,
    input  logic [31:0]         color,
    input  logic [15:0]         tiling,
    input  qbve_cmd_t           cmd,
    output qbve_status_t        status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic signed [31:0]  vert_x,
    output logic signed [31:0]  vert_y,
    output logic signed [31:0]  vert_z,
    output logic [31:0]         vert_color,
    output logic                tex_u,
    output logic                tex_v,
    output logic [4:0]          tex_slot,
    output logic [15:0]         vert_tiling,
    output logic [14:0]         batch_quads,
    output logic [5:0]          slots_used,
    output logic                last
);

    function automatic logic signed [31:0] sat32(logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < -36'sh080000000)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [1:0]          func_reg;
    logic signed [31:0]  px_reg, py_reg, pz_reg, sx_reg, sy_reg;
    logic                tex_reg;
    logic [31:0]         tid_reg, col_reg;
    logic [15:0]         til_reg;
    logic signed [15:0]  sin_reg, cos_reg;
    logic signed [47:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic [31:0]         slot_ids [SLOTS];
    logic [5:0]          slot_count_reg;
    logic [14:0]         quad_count_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [14:0]         quad_limit_reg;
    logic                out_valid_reg;
    logic                kind_reg, u_reg, v_reg, last_reg;
    logic signed [31:0]  vx_reg, vy_reg, vz_reg;
    logic [31:0]         vcol_reg;
    logic [4:0]          vslot_reg;
    logic [15:0]         vtil_reg;
    logic [14:0]         bq_reg;
    logic [5:0]          su_reg;

    logic [SINE_BITS-1:0] idx;
    logic [14:0]          lim;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 cx_pos, cy_pos;
    logic signed [49:0]   ta, tb, tc, td, rxs, rys;
    logic signed [35:0]   sumx, sumy;
    logic                 out_free;

    assign idx = angle[15 -: SINE_BITS];

    // input capture and table lookup
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            sx_reg   <= size_x;
            sy_reg   <= size_y;
            tex_reg  <= textured;
            tid_reg  <= texture_id;
            col_reg  <= color;
            til_reg  <= tiling;
            sin_reg  <= SIN_LUT[idx];
            cos_reg  <= SIN_LUT[idx + SINE_BITS'(SINE_ENTRIES / 4)];
        end
    end

    // rotation products
    always_ff @(posedge clk)
    begin
        pa_reg <= sx_reg * cos_reg;
        pb_reg <= sy_reg * sin_reg;
        pc_reg <= sx_reg * sin_reg;
        pd_reg <= sy_reg * cos_reg;
    end

    // effective limit and flush decision
    always_comb
    begin
        if (quad_limit_reg == 15'd0)
            lim = 15'd1;
        else if (quad_limit_reg > 15'(MAX_QUADS))
            lim = 15'(MAX_QUADS);
        else
            lim = quad_limit_reg;
    end

    assign out_free          = !out_valid_reg || !out_stall;
    assign status.func       = func_reg;
    assign status.need_flush = (quad_count_reg >= lim) || (slot_count_reg >= 6'(SLOTS));
    assign status.out_free   = out_free;

    // parallel slot compare, lowest match wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = 1; k < SLOTS; k++)
        begin
            if (!hit && (6'(k) < slot_count_reg) && (slot_ids[k] == tid_reg))
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(k);
            end
        end
    end

    // slot table, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.slot_assign && tex_reg && !hit)
            slot_ids[slot_count_reg[SLOT_W-1:0]] <= tid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_assign)
        begin
            if (!tex_reg)
                slot_reg <= '0;
            else if (hit)
                slot_reg <= hit_idx;
            else
                slot_reg <= slot_count_reg[SLOT_W-1:0];
        end
    end

    // batch counters and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= 6'd1;
            quad_count_reg <= 15'd0;
            quad_limit_reg <= QUAD_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                quad_limit_reg <= cfg_wdata;
            if (cmd.clr_batch)
            begin
                slot_count_reg <= 6'd1;
                quad_count_reg <= 15'd0;
            end
            else
            begin
                if (cmd.slot_assign && tex_reg && !hit)
                    slot_count_reg <= slot_count_reg + 6'd1;
                if (cmd.emit_vert && cmd.corner == 2'd3)
                    quad_count_reg <= quad_count_reg + 15'd1;
            end
        end
    end

    // corner transform with rounding and saturation
    always_comb
    begin
        cx_pos = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
        cy_pos = cmd.corner[1];
        ta     = cx_pos ? 50'(pa_reg) : -50'(pa_reg);
        tb     = cy_pos ? 50'(pb_reg) : -50'(pb_reg);
        tc     = cx_pos ? 50'(pc_reg) : -50'(pc_reg);
        td     = cy_pos ? 50'(pd_reg) : -50'(pd_reg);
        rxs    = (ta - tb + 50'sd16384) >>> 15;
        rys    = (tc + td + 50'sd16384) >>> 15;
        sumx   = 36'(px_reg) + rxs[35:0];
        sumy   = 36'(py_reg) + rys[35:0];
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_flush || cmd.emit_vert)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_flush)
        begin
            kind_reg  <= 1'b1;
            vx_reg    <= '0;
            vy_reg    <= '0;
            vz_reg    <= '0;
            vcol_reg  <= '0;
            u_reg     <= 1'b0;
            v_reg     <= 1'b0;
            vslot_reg <= '0;
            vtil_reg  <= '0;
            bq_reg    <= quad_count_reg;
            su_reg    <= slot_count_reg;
            last_reg  <= cmd.flush_last;
        end
        else if (cmd.emit_vert)
        begin
            kind_reg  <= 1'b0;
            vx_reg    <= sat32(sumx);
            vy_reg    <= sat32(sumy);
            vz_reg    <= pz_reg;
            vcol_reg  <= tex_reg ? 32'hFFFFFFFF : col_reg;
            u_reg     <= cx_pos;
            v_reg     <= cy_pos;
            vslot_reg <= 5'(slot_reg);
            vtil_reg  <= tex_reg ? til_reg : 16'h0100;
            bq_reg    <= '0;
            su_reg    <= '0;
            last_reg  <= (cmd.corner == 2'd3);
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign vert_x      = vx_reg;
    assign vert_y      = vy_reg;
    assign vert_z      = vz_reg;
    assign vert_color  = vcol_reg;
    assign tex_u       = u_reg;
    assign tex_v       = v_reg;
    assign tex_slot    = vslot_reg;
    assign vert_tiling = vtil_reg;
    assign batch_quads = bq_reg;
    assign slots_used  = su_reg;
    assign last        = last_reg;

endmodule

// ===== design/quad_batch_vertex_expander_unit.sv =====
`timescale 1ns / 1ps
// draw request: decode, optional flush, slot lookup, then four corner vertex transactions,
//   one vertex per cycle while the output register is not stalled; no new request is
//   accepted until the last corner has been emitted
// end request: decode, then the final flush; begin and unknown requests: decode only
// rate is set by the sequencer; one transaction per cycle while the output is not stalled
// reset: batch empty, slot count 1, quad limit 10000; the slot table is not cleared
// ----------------------------------------------------------------------------
// quad_batch_vertex_expander_unit
// expands sprite requests into four transformed vertices with batch flushes
// ----------------------------------------------------------------------------
`include "quad_batch_vertex_expander_unit_macros.svh"
module quad_batch_vertex_expander_unit
    import qbve_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [14:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  size_x,
    input  logic signed [31:0]  size_y,
    input  logic [15:0]         angle,
    input  logic                textured,
    input  logic [31:0]         texture_id,
    input  logic [31:0]         color,
    input  logic [15:0]         tiling,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic signed [31:0]  vert_x,
    output logic signed [31:0]  vert_y,
    output logic signed [31:0]  vert_z,
    output logic [31:0]         vert_color,
    output logic                tex_u,
    output logic                tex_v,
    output logic [4:0]          tex_slot,
    output logic [15:0]         vert_tiling,
    output logic [14:0]         batch_quads,
    output logic [5:0]          slots_used,
    output logic                last
);

    qbve_cmd_t    cmd;
    qbve_status_t status;

    // sequencer
    qbve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    qbve_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .size_x      (size_x),
        .size_y      (size_y),
        .angle       (angle),
        .textured    (textured),
        .texture_id  (texture_id),
        .color       (color),
        .tiling      (tiling),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .vert_color  (vert_color),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .tex_slot    (tex_slot),
        .vert_tiling (vert_tiling),
        .batch_quads (batch_quads),
        .slots_used  (slots_used),
        .last        (last)
    );

    // checks
    `QBVE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `QBVE_ASSERT_IMPL(a_vert_no_counts, out_valid && !kind, batch_quads == 15'd0 && slots_used == 6'd0)
    `QBVE_ASSERT_IMPL(a_flush_zero_vert, out_valid && kind, tex_slot == 5'd0 && vert_x == 32'sd0)

endmodule

// ===== dv/quad_batch_vertex_expander_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_batch_vertex_expander_unit_tb
// drives sprite requests with random idling on both sides and compares every
// vertex and flush transaction against a cycle-free prediction of the batcher
// ----------------------------------------------------------------------------
module quad_batch_vertex_expander_unit_tb
    import qbve_pkg::*;
();

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] px, py, pz, sx, sy;
        logic [15:0]        angle;
        logic               textured;
        logic [31:0]        tex_id;
        logic [31:0]        color;
        logic [15:0]        tiling;
    } sprite_req_t;

    typedef struct {
        logic               kind;
        logic signed [31:0] x, y, z;
        logic [31:0]        color;
        logic               u, v;
        logic [4:0]         slot;
        logic [15:0]        tiling;
        logic [14:0]        quads;
        logic [5:0]         slots;
        logic               last;
    } vertex_rec_t;

    // q1.14 sine of a phase in 2^-32 turn, odd polynomial on the reduced quarter wave
    function automatic logic signed [15:0] phase_sine(logic [31:0] ph);
        bit [63:0] r, x, x2, t, s;
        logic signed [15:0] mag;
        r = {34'd0, ph[29:0]};
        if (ph[30])
            r = 64'd1073741824 - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        mag = 16'((s + 64'd32768) >> 16);
        return ph[31] ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(v);
    endfunction

    // ------------------------------------------------------------------------
    // scoreboard: batch state and the queue of expected transactions
    // ------------------------------------------------------------------------
    class quad_batch_scoreboard;
        logic [31:0]  slot_tag [SLOTS];
        int unsigned  used_slots;
        int unsigned  batch_len;
        int unsigned  limit_reg;
        longint       sin_q14 [SINE_ENTRIES];
        longint       cos_q14 [SINE_ENTRIES];
        vertex_rec_t  pending_verts [$];
        int           errors;

        function new();
            for (int i = 0; i < SINE_ENTRIES; i++)
            begin
                sin_q14[i] = phase_sine(32'(i) << 22);
                cos_q14[i] = phase_sine((32'(i) << 22) + 32'h40000000);
            end
            used_slots = 1;
            batch_len  = 0;
            limit_reg  = 10000;
            errors     = 0;
        endfunction

        function void set_limit(logic [14:0] val);
            limit_reg = val;
        endfunction

        function void push_flush(logic is_last);
            vertex_rec_t r;
            r = '{default: '0};
            r.kind  = 1'b1;
            r.quads = 15'(batch_len);
            r.slots = 6'(used_slots);
            r.last  = is_last;
            pending_verts.push_back(r);
        endfunction

        // accepted request: predict its transactions
        function void note_request(sprite_req_t q);
            int unsigned lim, slot, idx;
            logic [31:0] col;
            logic [15:0] til;
            longint lx, ly, c, s;
            vertex_rec_t r;
            if (q.func == FUNC_BEGIN)
            begin
                used_slots = 1;
                batch_len  = 0;
                return;
            end
            if (q.func == FUNC_END)
            begin
                push_flush(1'b1);
                return;
            end
            if (q.func != FUNC_DRAW)
                return;
            lim = (limit_reg < 1) ? 1 : (limit_reg > MAX_QUADS) ? MAX_QUADS : limit_reg;
            // forced flush on full batch or full slot table
            if (batch_len >= lim || used_slots >= SLOTS)
            begin
                push_flush(1'b0);
                used_slots = 1;
                batch_len  = 0;
            end
            if (q.textured)
            begin
                slot = 0;
                for (int k = 1; k < used_slots; k++)
                begin
                    if (slot == 0 && slot_tag[k] == q.tex_id)
                        slot = k;
                end
                if (slot == 0)
                begin
                    slot = used_slots;
                    slot_tag[slot] = q.tex_id;
                    used_slots++;
                end
                col = 32'hFFFFFFFF;
                til = q.tiling;
            end
            else
            begin
                slot = 0;
                col  = q.color;
                til  = 16'h0100;
            end
            idx = q.angle >> 6;
            c = cos_q14[idx];
            s = sin_q14[idx];
            // corners in order (-,-) (+,-) (+,+) (-,+)
            for (int k = 0; k < 4; k++)
            begin
                lx = (k == 1 || k == 2) ? longint'(q.sx) : -longint'(q.sx);
                ly = (k >= 2) ? longint'(q.sy) : -longint'(q.sy);
                r = '{default: '0};
                r.x      = clamp32(longint'(q.px) + ((lx * c - ly * s + 16384) >>> 15));
                r.y      = clamp32(longint'(q.py) + ((lx * s + ly * c + 16384) >>> 15));
                r.z      = q.pz;
                r.color  = col;
                r.u      = (k == 1 || k == 2);
                r.v      = (k >= 2);
                r.slot   = 5'(slot);
                r.tiling = til;
                r.last   = (k == 3);
                pending_verts.push_back(r);
            end
            batch_len++;
        endfunction

        function void check_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted output transaction against the oldest expectation
        function void check_vertex(vertex_rec_t a);
            vertex_rec_t e;
            if (pending_verts.size() == 0)
            begin
                $error("unexpected output transaction, kind %0d", a.kind);
                errors++;
                return;
            end
            e = pending_verts.pop_front();
            check_field("kind", e.kind, a.kind);
            check_field("vert_x", e.x, a.x);
            check_field("vert_y", e.y, a.y);
            check_field("vert_z", e.z, a.z);
            check_field("vert_color", e.color, a.color);
            check_field("tex_u", e.u, a.u);
            check_field("tex_v", e.v, a.v);
            check_field("tex_slot", e.slot, a.slot);
            check_field("vert_tiling", e.tiling, a.tiling);
            check_field("batch_quads", e.quads, a.quads);
            check_field("slots_used", e.slots, a.slots);
            check_field("last", e.last, a.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = FUNC_DRAW;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, size_x = '0, size_y = '0;
    logic [15:0] angle = '0;
    logic textured = 1'b0;
    logic [31:0] texture_id = '0, color = '0;
    logic [15:0] tiling = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind, tex_u, tex_v, last;
    logic signed [31:0] vert_x, vert_y, vert_z;
    logic [31:0] vert_color;
    logic [4:0] tex_slot;
    logic [15:0] vert_tiling;
    logic [14:0] batch_quads;
    logic [5:0] slots_used;

    quad_batch_scoreboard sb = new();
    logic [31:0] tex_pool [40];
    int pool_span = 4;
    int stall_mode = 0;
    int cycles = 0;

    quad_batch_vertex_expander_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .size_x(size_x), .size_y(size_y),
        .angle(angle), .textured(textured), .texture_id(texture_id), .color(color),
        .tiling(tiling), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .vert_color(vert_color),
        .tex_u(tex_u), .tex_v(tex_v), .tex_slot(tex_slot), .vert_tiling(vert_tiling),
        .batch_quads(batch_quads), .slots_used(slots_used), .last(last)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_vertex('{kind, vert_x, vert_y, vert_z, vert_color, tex_u, tex_v,
                              tex_slot, vert_tiling, batch_quads, slots_used, last});
    end

    // receiver stall: calm stretches, short stalls, occasional long ones
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h00C80000)) - 32'sh00640000);
        endcase
    endfunction

    function automatic sprite_req_t random_request();
        sprite_req_t q;
        int sel;
        sel = $urandom_range(0, 99);
        q.func = (sel < 82) ? FUNC_DRAW : (sel < 89) ? FUNC_END :
                 (sel < 96) ? FUNC_BEGIN : FUNC_UNUSED;
        q.px = pick_coord();
        q.py = pick_coord();
        q.pz = $urandom;
        q.sx = pick_coord();
        q.sy = pick_coord();
        q.angle = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
        q.textured = $urandom_range(0, 2) != 0;
        q.tex_id = ($urandom_range(0, 5) == 0) ? $urandom : tex_pool[$urandom_range(0, pool_span)];
        q.color = $urandom;
        q.tiling = 16'($urandom);
        return q;
    endfunction

    // one request through the input handshake, then an optional gap
    task automatic send_request(sprite_req_t q, int gap);
        @(negedge clk);
        func = q.func;
        pos_x = q.px;
        pos_y = q.py;
        pos_z = q.pz;
        size_x = q.sx;
        size_y = q.sy;
        angle = q.angle;
        textured = q.textured;
        texture_id = q.tex_id;
        color = q.color;
        tiling = q.tiling;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(q);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic int random_gap();
        int g;
        g = $urandom_range(0, 99);
        return (g < 55) ? 0 : (g < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_verts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(logic [14:0] val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_limit(val);
    endtask

    function automatic sprite_req_t make_draw(logic signed [31:0] px, logic signed [31:0] sx,
                                              logic [15:0] ang, logic tx, logic [31:0] id);
        sprite_req_t q;
        q = '{func: FUNC_DRAW, px: px, py: -px, pz: px ^ 32'h5A5A5A5A, sx: sx, sy: sx,
              angle: ang, textured: tx, tex_id: id, color: ~id, tiling: 16'hFFFF};
        return q;
    endfunction

    initial
    begin
        sprite_req_t q;
        logic [14:0] limits [7];
        for (int i = 0; i < 40; i++)
            tex_pool[i] = $urandom;
        limits = '{15'd1, 15'd3, 15'd0, 15'd32767, 15'd16384, 15'd10000, 15'd7};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every request code, slot reuse, empty end flush
        q = make_draw(32'sh00010000, 32'sh00010000, 16'h0000, 1'b0, 32'h0);
        q.func = FUNC_END;
        send_request(q, 0);
        send_request(make_draw(32'sh00000000, 32'sh00010000, 16'h0000, 1'b0, 32'h0), 0);
        send_request(make_draw(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h4000, 1'b0, 32'h0), 1);
        send_request(make_draw(32'sh80000000, 32'sh80000000, 16'hFFFF, 1'b1, 32'hFFFFFFFF), 0);
        send_request(make_draw(32'sh7FFFFFFF, 32'sh80000000, 16'h8000, 1'b1, 32'hFFFFFFFF), 0);
        send_request(make_draw(32'sh80000000, 32'sh7FFFFFFF, 16'hC000, 1'b1, 32'h00000000), 2);
        send_request(make_draw(32'sh00123456, -32'sh00030000, 16'h2000, 1'b1, 32'h00000001), 0);
        send_request(make_draw(-32'sh00123456, 32'sh00008000, 16'h003F, 1'b0, 32'hFFFFFFFF), 0);
        q.func = FUNC_UNUSED;
        send_request(q, 0);
        q.func = FUNC_END;
        send_request(q, 0);
        q.func = FUNC_BEGIN;
        send_request(q, 0);
        q.func = FUNC_END;
        send_request(q, 3);

        // random phases, each under its own quad limit
        for (int ph = 0; ph < 7; ph++)
        begin
            write_limit(limits[ph]);
            pool_span = (ph % 2) ? 39 : 4;
            if (ph == 3)
            begin
                // fill the slot table with fresh textures to force a slot flush
                for (int i = 0; i < 34; i++)
                begin
                    q = random_request();
                    q.func = FUNC_DRAW;
                    q.textured = 1'b1;
                    q.tex_id = tex_pool[i % 40] + 32'(i / 40);
                    send_request(q, random_gap());
                end
            end
            for (int i = 0; i < 24; i++)
                send_request(random_request(), random_gap());
        end
        write_limit(15'($urandom_range(2, 40)));
        for (int i = 0; i < 20; i++)
            send_request(random_request(), random_gap());

        wait_idle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== quad_batch_vertex_expander_unit.f =====
+incdir+design
design/qbve_pkg.sv
design/qbve_ctrl.sv
design/qbve_dp.sv
design/quad_batch_vertex_expander_unit.sv
dv/quad_batch_vertex_expander_unit_tb.sv
